// ===== rtl/tcm_pkg.sv =====
// Shared types and constants for the TCM router with CP15 control.
// No dependencies.
`default_nettype none
package tcm_pkg;
    localparam int ITCM_BYTES = 32768;
    localparam int DTCM_BYTES = 16384;
    localparam int ITCM_WORDS = ITCM_BYTES / 4;
    localparam int DTCM_WORDS = DTCM_BYTES / 4;
    localparam int ITCM_AW = $clog2(ITCM_WORDS);
    localparam int DTCM_AW = $clog2(DTCM_WORDS);

    localparam logic [2:0] CMD_DREAD  = 3'd0;
    localparam logic [2:0] CMD_DWRITE = 3'd1;
    localparam logic [2:0] CMD_FETCH  = 3'd2;
    localparam logic [2:0] CMD_CPREAD = 3'd3;
    localparam logic [2:0] CMD_CPWR   = 3'd4;
    localparam logic [2:0] CMD_WAKE   = 3'd5;

    localparam logic [1:0] ROUTE_ITCM = 2'd0;
    localparam logic [1:0] ROUTE_DTCM = 2'd1;
    localparam logic [1:0] ROUTE_BUS  = 2'd2;
    localparam logic [1:0] ROUTE_CP   = 2'd3;

    localparam logic [1:0] SZ_BYTE = 2'd0;
    localparam logic [1:0] SZ_HALF = 2'd1;

    localparam logic [31:0] CTRL_RESET = 32'h0005307d;
    localparam logic [31:0] CTRL_WMASK = 32'h000ff085;
    localparam logic [31:0] ID_MAIN    = 32'h41059461;
    localparam logic [31:0] ID_CACHE   = 32'h0f0d2112;
    localparam logic [31:0] ID_TCM     = 32'h00140180;

    // Controller to datapath commands
    typedef struct packed {
        logic capture;  // latch a new word
        logic execute;  // do TCM access and update registers
    } tcm_cmd_t;

    // true when offset falls inside a window of 512 << code bytes; code 0 never matches
    function automatic logic in_window(input logic [31:0] off, input logic [4:0] code);
        logic [63:0] size;
        size = 64'd512 << code;
        if (code == 5'd0) return 1'b0;
        if (code >= 5'd23) return 1'b1;
        return {32'd0, off} < size;
    endfunction
endpackage
`default_nettype wire

// ===== rtl/tcm_router_with_cp15_control.sv =====
// Top level: TCM router with CP15 control registers.
// Depends on tcm_pkg, tcm_ctrl, tcm_dp.
//
// Usage: raise start with a command word on the input ports while busy is
// low; the word is taken at that edge. busy then stays high through the
// S_EXEC and S_RESP states. In S_RESP done pulses high for exactly one
// cycle with read_data, route, bus_address, halted, vector_high and v5_mode
// valid. The receiver cannot stall; it must take the word in that cycle.
// A new word is taken only once the capture, single-port TCM access and
// response steps are through and busy is low again.
// Reset (rst_n low, asynchronous) returns to idle, loads the control word
// with 0x0005307d and clears TCM windows and the halt flag. TCM contents
// are undefined until written; no clearing pass is run.
`default_nettype none
module tcm_router_with_cp15_control
    import tcm_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        start,
    output logic             busy,
    output logic             done,
    input  wire logic [2:0]  command,
    input  wire logic [31:0] address,
    input  wire logic [1:0]  size_code,
    input  wire logic        sign_extend,
    input  wire logic [31:0] write_data,
    input  wire logic [3:0]  cp_primary,
    input  wire logic [3:0]  cp_secondary,
    input  wire logic [2:0]  cp_opcode,
    output logic [31:0]      read_data,
    output logic [1:0]       route,
    output logic [31:0]      bus_address,
    output logic             halted,
    output logic             vector_high,
    output logic             v5_mode
);
    tcm_cmd_t cmd;

    tcm_ctrl u_ctrl (
        .clk(clk), .rst_n(rst_n), .start(start), .busy(busy), .done(done), .cmd(cmd)
    );

    tcm_dp u_dp (
        .clk(clk), .rst_n(rst_n), .cmd(cmd),
        .command(command), .address(address), .size_code(size_code),
        .sign_extend(sign_extend), .write_data(write_data),
        .cp_primary(cp_primary), .cp_secondary(cp_secondary), .cp_opcode(cp_opcode),
        .read_data(read_data), .route(route), .bus_address(bus_address),
        .halted(halted), .vector_high(vector_high), .v5_mode(v5_mode)
    );
endmodule
`default_nettype wire

// ===== rtl/tcm_ctrl.sv =====
// Sequencing controller: capture, execute, respond.
// Depends on tcm_pkg.
`default_nettype none
module tcm_ctrl
    import tcm_pkg::*;
(
    input  wire logic clk,
    input  wire logic rst_n,
    input  wire logic start,
    output logic      busy,
    output logic      done,
    output tcm_cmd_t  cmd
);
    typedef enum logic [1:0] {S_IDLE, S_EXEC, S_RESP} state_t;
    state_t state_reg, state_next;

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE: if (start) state_next = S_EXEC;
            S_EXEC: state_next = S_RESP;
            S_RESP: state_next = S_IDLE;
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= S_IDLE;
        else
            state_reg <= state_next;
    end

    assign busy        = (state_reg != S_IDLE);
    assign done        = (state_reg == S_RESP);
    assign cmd.capture = (state_reg == S_IDLE) && start;
    assign cmd.execute = (state_reg == S_EXEC);
endmodule
`default_nettype wire

// ===== rtl/tcm_dp.sv =====
// Datapath: TCM arrays, CP15 registers, routing and read formatting.
// Depends on tcm_pkg.
`default_nettype none
module tcm_dp
    import tcm_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire tcm_cmd_t    cmd,
    input  wire logic [2:0]  command,
    input  wire logic [31:0] address,
    input  wire logic [1:0]  size_code,
    input  wire logic        sign_extend,
    input  wire logic [31:0] write_data,
    input  wire logic [3:0]  cp_primary,
    input  wire logic [3:0]  cp_secondary,
    input  wire logic [2:0]  cp_opcode,
    output logic [31:0]      read_data,
    output logic [1:0]       route,
    output logic [31:0]      bus_address,
    output logic             halted,
    output logic             vector_high,
    output logic             v5_mode
);
    logic [31:0] imem [ITCM_WORDS];
    logic [31:0] dmem [DTCM_WORDS];

    // captured word
    logic [2:0]  cmd_reg;
    logic [31:0] addr_reg, wd_reg;
    logic [1:0]  sz_reg;
    logic        sx_reg;
    logic [3:0]  cn_reg, cm_reg;
    logic [2:0]  cp_reg;

    logic [31:0] ctrl_reg;
    logic [19:0] dbase_reg;
    logic [4:0]  dsize_reg, isize_reg;
    logic        halt_reg;

    logic [31:0] a, off_d;
    logic        ihit, dhit, is_read, is_fetch;
    logic [ITCM_AW-1:0] iidx;
    logic [DTCM_AW-1:0] didx;
    logic [31:0] cpval, wmask, wshift;
    logic [4:0]  sh;
    logic [31:0] iword_reg, dword_reg;
    logic [1:0]  route_reg;

    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            cmd_reg  <= command;
            addr_reg <= address;
            sz_reg   <= (size_code == 2'd3) ? 2'd2 : size_code;
            sx_reg   <= sign_extend;
            wd_reg   <= write_data;
            cn_reg   <= cp_primary;
            cm_reg   <= cp_secondary;
            cp_reg   <= cp_opcode;
        end
    end

    // aligned address and window decode
    always_comb
    begin
        is_fetch = (cmd_reg == CMD_FETCH);
        is_read  = (cmd_reg == CMD_DREAD) || is_fetch;
        if (is_fetch || sz_reg == 2'd2) a = {addr_reg[31:2], 2'b00};
        else if (sz_reg == SZ_HALF)     a = {addr_reg[31:1], 1'b0};
        else                            a = addr_reg;
        off_d = a - {dbase_reg, 12'd0};
        ihit = ctrl_reg[18] && !(is_read && ctrl_reg[19])
               && in_window(is_fetch ? addr_reg : a, isize_reg);
        // DTCM window is tested on the wrapped offset above the base
        dhit = !is_fetch && ctrl_reg[16] && !(is_read && ctrl_reg[17])
               && in_window(off_d, dsize_reg);
        iidx = a[ITCM_AW+1:2];
        didx = a[DTCM_AW+1:2];
        sh   = {a[1:0], 3'b000};
        unique case (sz_reg)
            SZ_BYTE: wmask = 32'h000000ff << sh;
            SZ_HALF: wmask = 32'h0000ffff << sh;
            default: wmask = 32'hffffffff;
        endcase
        wshift = wd_reg << sh;
        cpval = 32'd0;
        if (cn_reg == 4'd0 && cm_reg == 4'd0)
            cpval = (cp_reg == 3'd1) ? ID_CACHE : (cp_reg == 3'd2) ? ID_TCM : ID_MAIN;
        else if (cn_reg == 4'd1 && cm_reg == 4'd0 && cp_reg == 3'd0)
            cpval = ctrl_reg;
        else if (cn_reg == 4'd9 && cm_reg == 4'd1 && cp_reg == 3'd0)
            cpval = {dbase_reg, 6'd0, dsize_reg, 1'b0};
        else if (cn_reg == 4'd9 && cm_reg == 4'd1 && cp_reg == 3'd1)
            cpval = {26'd0, isize_reg, 1'b0};
    end

    // memories: registered read, byte-lane write
    always_ff @(posedge clk)
    begin
        if (cmd.execute)
        begin
            iword_reg <= imem[iidx];
            dword_reg <= dmem[didx];
            for (int b = 0; b < 4; b++)
            begin
                if (cmd_reg == CMD_DWRITE && ihit && wmask[8*b])
                    imem[iidx][8*b +: 8] <= wshift[8*b +: 8];
                if (cmd_reg == CMD_DWRITE && !ihit && dhit && wmask[8*b])
                    dmem[didx][8*b +: 8] <= wshift[8*b +: 8];
            end
        end
    end

    // route, control registers and result
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ctrl_reg  <= CTRL_RESET;
            dbase_reg <= '0;
            dsize_reg <= '0;
            isize_reg <= '0;
            halt_reg  <= 1'b0;
        end
        else if (cmd.execute)
        begin
            if (cmd_reg == CMD_WAKE)
                halt_reg <= 1'b0;
            if (cmd_reg == CMD_CPWR)
            begin
                if (cn_reg == 4'd1 && cm_reg == 4'd0 && cp_reg == 3'd0)
                    ctrl_reg <= (ctrl_reg & ~CTRL_WMASK) | (wd_reg & CTRL_WMASK);
                else if (cn_reg == 4'd7 && ((cm_reg == 4'd0 && cp_reg == 3'd4)
                         || (cm_reg == 4'd8 && cp_reg == 3'd2)))
                    halt_reg <= 1'b1;
                else if (cn_reg == 4'd9 && cm_reg == 4'd1 && cp_reg == 3'd0)
                begin
                    dsize_reg <= wd_reg[5:1];
                    dbase_reg <= wd_reg[31:12];
                end
                else if (cn_reg == 4'd9 && cm_reg == 4'd1 && cp_reg == 3'd1)
                    isize_reg <= wd_reg[5:1];
            end
        end
    end

    logic [31:0] bus_reg, cpv_reg;
    always_ff @(posedge clk)
    begin
        if (cmd.execute)
        begin
            cpv_reg <= cpval;
            bus_reg <= a;
            if (cmd_reg == CMD_DREAD || cmd_reg == CMD_DWRITE || is_fetch)
                route_reg <= ihit ? ROUTE_ITCM : dhit ? ROUTE_DTCM : ROUTE_BUS;
            else
                route_reg <= ROUTE_CP;
        end
    end

    // read formatting
    logic [31:0] w, lane;
    logic [4:0]  rot;
    always_comb
    begin
        w = (route_reg == ROUTE_ITCM) ? iword_reg : dword_reg;
        lane = w >> {bus_reg[1:0], 3'b000};
        rot = {addr_reg[1:0], 3'b000};
        read_data = 32'd0;
        if (cmd_reg == CMD_CPREAD)
            read_data = cpv_reg;
        else if (is_fetch && route_reg == ROUTE_ITCM)
            read_data = iword_reg;
        else if (cmd_reg == CMD_DREAD && route_reg != ROUTE_BUS)
        begin
            case (sz_reg)
                SZ_BYTE: read_data = {{24{sx_reg & lane[7]}}, lane[7:0]};
                SZ_HALF: read_data = {{16{sx_reg & lane[15]}}, lane[15:0]};
                default: read_data = (w >> rot) | (w << (6'd32 - {1'b0, rot}));
            endcase
        end
        route       = route_reg;
        bus_address = (route_reg == ROUTE_BUS) ? bus_reg : 32'd0;
        halted      = halt_reg;
        vector_high = ctrl_reg[13];
        v5_mode     = ~ctrl_reg[15];
    end
endmodule
`default_nettype wire

// ===== rtl/tcm_checker.sv =====
// Port-level checks for the TCM router, bound to the top level.
// Depends on tcm_pkg.
`default_nettype none
module tcm_checker
    import tcm_pkg::*;
(
    input wire logic        clk,
    input wire logic        rst_n,
    input wire logic        start,
    input wire logic        busy,
    input wire logic        done,
    input wire logic [1:0]  route,
    input wire logic [31:0] bus_address
);
    // accepted word must be followed by done
    a_lat: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |-> ##2 done) else $error("done missing");
    // done only while busy
    a_busy: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> busy) else $error("done while idle");
    // done is one cycle wide
    a_pulse: assert property (@(posedge clk) disable iff (!rst_n)
        done |=> !done) else $error("done held");
    // bus address only on bus route
    a_bus: assert property (@(posedge clk) disable iff (!rst_n)
        (done && route != ROUTE_BUS) |-> (bus_address == 32'd0))
        else $error("stray bus address");
endmodule

bind tcm_router_with_cp15_control tcm_checker u_chk (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy), .done(done),
    .route(route), .bus_address(bus_address)
);
`default_nettype wire
